// File: rtl/ledfad_pkg.sv
// shared types and constants for the led fade dimmer
`default_nettype none
package ledfad_pkg;
    localparam int NUM_CHANNELS_DEF   = 3;
    localparam int SENS_FULL_DEF      = 100;

    localparam int LEVEL_W  = 8;
    localparam int LUX_W    = 16;
    localparam int SCALE_W  = 17;
    localparam int DEN_W    = 24;
    localparam int REM_W    = DEN_W + 1;
    localparam int QUOT_W   = 17;
    localparam int CNT_W    = 5;
    localparam int PW_W     = 10;
    localparam int CFG_W    = 16;
    localparam int REQ_W    = 3;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 17'h10000;

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 43699
    localparam logic [7:0]  PW_KNEE  = 8'd100;
    localparam logic [12:0] PW_RECIP = 13'd5243;
    localparam int          PW_SHIFT = 19;

    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_LUX    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TARGET = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ENABLE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FAULT  = 3'd4;

    localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [1:0] CFG_LUX_SENS  = 2'd1;
    localparam logic [1:0] CFG_MAX_LUX   = 2'd2;
    localparam logic [1:0] CFG_LUX_HYST  = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;
endpackage
`default_nettype wire

// File: rtl/ledfad_div.sv
// bit-serial restoring divider for the ambient reduction, one quotient bit per cycle
`default_nettype none
module ledfad_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [ledfad_pkg::DEN_W-1:0]    num,
    input  wire logic [ledfad_pkg::DEN_W-1:0]    den,
    output ledfad_pkg::div_stat_t                stat,
    output logic      [ledfad_pkg::QUOT_W-1:0]   quot
);
    logic [ledfad_pkg::REM_W-1:0]  rem_reg;
    logic [ledfad_pkg::DEN_W-1:0]  den_reg;
    logic [ledfad_pkg::QUOT_W-1:0] quot_reg;
    logic [ledfad_pkg::CNT_W-1:0]  cnt_reg;
    logic                          done_reg;
    logic                          ge;
    logic [ledfad_pkg::REM_W-1:0]  rem_sub;

    // numerator never exceeds the divisor, so the first bit is the integer part
    assign ge      = rem_reg >= {1'b0, den_reg};
    assign rem_sub = ge ? rem_reg - {1'b0, den_reg} : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                quot_reg <= '0;
                cnt_reg  <= ledfad_pkg::CNT_W'(ledfad_pkg::QUOT_W);
            end else if (cnt_reg != '0) begin
                rem_reg  <= {rem_sub[ledfad_pkg::REM_W-2:0], 1'b0};
                quot_reg <= {quot_reg[ledfad_pkg::QUOT_W-2:0], ge};
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == ledfad_pkg::CNT_W'(1));
            end
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quot      = quot_reg;
endmodule
`default_nettype wire

// File: rtl/ledfad_pwm.sv
// two-stage pulse width: square / knee via reciprocal, or level if under knee
`default_nettype none
module ledfad_pwm (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             start,
    input  wire logic [ledfad_pkg::LEVEL_W-1:0]   level,
    output logic                                  done,
    output logic      [ledfad_pkg::PW_W-1:0]      pulse_width
);
    logic [2*ledfad_pkg::LEVEL_W-1:0] sq_reg;
    logic [ledfad_pkg::LEVEL_W-1:0]   lvl_reg;
    logic                             v1_reg;
    logic                             done_reg;
    logic [ledfad_pkg::PW_W-1:0]      pw_reg;
    logic [28:0]                      prod;

    assign prod = sq_reg * ledfad_pkg::PW_RECIP;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= start;
            done_reg <= v1_reg;
            if (start) begin
                sq_reg  <= level * level;
                lvl_reg <= level;
            end
            if (v1_reg) begin
                pw_reg <= (lvl_reg < ledfad_pkg::PW_KNEE)
                          ? {2'b00, lvl_reg}
                          : prod[ledfad_pkg::PW_SHIFT +: ledfad_pkg::PW_W];
            end
        end
    end

    assign done        = done_reg;
    assign pulse_width = pw_reg;
endmodule
`default_nettype wire

// File: rtl/led_fade_ambient_dimmer_core.sv
// top level of the led fade dimmer with ambient compensation
// Usage: requests arrive on the s_ stream, request kind in s_tuser. A tick with a
// fade running yields one transaction per channel on the m_ stream, the final one
// with m_tlast; every other request yields nothing. Settings go through the
// cfg_ write port; the user must write them only while the block is idle,
// as the block itself does not enforce it. A tick walks the channels one at a
// time: target multiply, step, two pulse width stages, output load. A lux sample
// is clamped and checked against the hysteresis, then waits on the bit-serial
// divider (one of 17 quotient bits per cycle) and the result load; a sample
// inside the hysteresis or with a zero maximum lux ends after the check.
// Set target, set enable and sensor fault finish in the cycle they are accepted.
// s_tready is high only between requests; one request is worked at a time.
// The output register holds a result while m_tready is low, and the channel walk
// waits on it, so nothing is lost under backpressure.
// Reset (aresetn, synchronous, active low) zeroes all levels, sets unity scale,
// marks sensor ok and enable on, stops any fade and restores register defaults.
`default_nettype none
module led_fade_ambient_dimmer_core #(
    parameter int NUM_CHANNELS           = ledfad_pkg::NUM_CHANNELS_DEF,
    parameter int SENSITIVITY_FULL_SCALE = ledfad_pkg::SENS_FULL_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // led_index[2:0], target_level[10:3], lux_value[26:11], enable_bit[27]
    input  wire logic [31:0] s_tdata,
    // req_type[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // channel[2:0], level[10:3], pulse_width[20:11], output_on[21], changed[22]
    output logic [23:0]      m_tdata,
    output logic             m_tlast
);
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LW   = ledfad_pkg::LEVEL_W;

    typedef enum logic [2:0] {
        S_IDLE, S_LUX_CLAMP, S_LUX_HYST, S_LUX_DIV,
        S_TGT, S_STEP, S_PWM, S_OUT
    } state_t;

    state_t state_reg;

    logic [7:0]  step_reg;
    logic [6:0]  sens_reg;
    logic [15:0] max_reg;
    logic [15:0] hyst_reg;

    logic [LW-1:0] cur_reg  [NUM_CHANNELS];
    logic [LW-1:0] des_reg  [NUM_CHANNELS];
    logic [LW-1:0] save_reg [NUM_CHANNELS];
    logic [ledfad_pkg::SCALE_W-1:0] scale_reg;
    logic [15:0] last_lux_reg;
    logic        have_lux_reg;
    logic        sensor_ok_reg;
    logic        soft_en_reg;
    logic        fade_reg;

    logic [15:0]     lux_reg;
    logic [CH_W-1:0] ch_reg;
    logic [LW-1:0]   tgt_reg;
    logic [LW-1:0]   lvl_reg;
    logic            moved_reg;
    logic            any_reg;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic [2:0]  in_req;
    logic [2:0]  in_idx;
    logic [7:0]  in_lvl;
    logic [15:0] in_lux;
    logic        in_en;
    logic        in_acc;

    assign in_req = s_tuser;
    assign in_idx = s_tdata[2:0];
    assign in_lvl = s_tdata[10:3];
    assign in_lux = s_tdata[26:11];
    assign in_en  = s_tdata[27];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // lux path
    logic [7:0]  sens_sat;
    logic [15:0] lux_diff;
    logic        lux_skip;
    logic [ledfad_pkg::DEN_W-1:0] div_num;
    logic [ledfad_pkg::DEN_W-1:0] div_den;
    logic        div_start;
    ledfad_pkg::div_stat_t div_st;
    logic [ledfad_pkg::QUOT_W-1:0] div_q;

    assign sens_sat = ({1'b0, sens_reg} > 8'(SENSITIVITY_FULL_SCALE))
                      ? 8'(SENSITIVITY_FULL_SCALE) : {1'b0, sens_reg};
    assign lux_diff = (last_lux_reg > lux_reg) ? last_lux_reg - lux_reg
                                               : lux_reg - last_lux_reg;
    assign lux_skip = have_lux_reg && (lux_diff < hyst_reg);
    assign div_num  = sens_sat * (max_reg - lux_reg);
    assign div_den  = 8'(SENSITIVITY_FULL_SCALE) * max_reg;
    assign div_start = (state_reg == S_LUX_HYST) && !lux_skip && (max_reg != '0);

    ledfad_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .stat    (div_st),
        .quot    (div_q)
    );

    // channel step
    logic [LW-1:0] cur_sel;
    logic [LW-1:0] des_sel;
    logic [24:0]   tgt_prod;
    logic [7:0]    step_eff;
    logic [LW-1:0] nxt;
    logic          moved;

    assign cur_sel  = cur_reg[ch_reg];
    assign des_sel  = des_reg[ch_reg];
    assign tgt_prod = des_sel * scale_reg;
    assign step_eff = (step_reg == '0) ? 8'd1 : step_reg;

    always_comb begin
        nxt   = cur_sel;
        moved = 1'b0;
        if (cur_sel > tgt_reg) begin
            nxt   = ((cur_sel - tgt_reg) > step_eff) ? cur_sel - step_eff : tgt_reg;
            moved = 1'b1;
        end else if (cur_sel < tgt_reg) begin
            nxt   = ((tgt_reg - cur_sel) > step_eff) ? cur_sel + step_eff : tgt_reg;
            moved = 1'b1;
        end
    end

    logic                      pwm_start;
    logic                      pwm_done;
    logic [ledfad_pkg::PW_W-1:0] pwm_pw;

    assign pwm_start = (state_reg == S_STEP);

    ledfad_pwm u_pwm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (pwm_start),
        .level       (nxt),
        .done        (pwm_done),
        .pulse_width (pwm_pw)
    );

    logic last_ch;
    assign last_ch = (ch_reg == CH_W'(NUM_CHANNELS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= 8'd1;
            sens_reg      <= '0;
            max_reg       <= 16'd200;
            hyst_reg      <= 16'd30;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                cur_reg[i]  <= '0;
                des_reg[i]  <= '0;
                save_reg[i] <= '0;
            end
            scale_reg     <= ledfad_pkg::SCALE_ONE;
            last_lux_reg  <= '0;
            have_lux_reg  <= 1'b0;
            sensor_ok_reg <= 1'b1;
            soft_en_reg   <= 1'b1;
            fade_reg      <= 1'b0;
            ch_reg        <= '0;
            any_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    ledfad_pkg::CFG_STEP_SIZE: step_reg <= cfg_wdata[7:0];
                    ledfad_pkg::CFG_LUX_SENS:  sens_reg <= cfg_wdata[6:0];
                    ledfad_pkg::CFG_MAX_LUX:   max_reg  <= cfg_wdata;
                    ledfad_pkg::CFG_LUX_HYST:  hyst_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            // the output load below owns m_tvalid_reg while in S_OUT
            if (m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (in_req)
                            ledfad_pkg::REQ_TICK: begin
                                if (fade_reg) begin
                                    ch_reg    <= '0;
                                    any_reg   <= 1'b0;
                                    state_reg <= S_TGT;
                                end
                            end
                            ledfad_pkg::REQ_LUX: begin
                                if (!fade_reg && soft_en_reg && sensor_ok_reg) begin
                                    lux_reg   <= in_lux;
                                    state_reg <= S_LUX_CLAMP;
                                end
                            end
                            ledfad_pkg::REQ_TARGET: begin
                                if ({1'b0, in_idx} < 4'(NUM_CHANNELS)) begin
                                    des_reg[in_idx[CH_W-1:0]] <= in_lvl;
                                    fade_reg <= 1'b1;
                                end
                            end
                            ledfad_pkg::REQ_ENABLE: begin
                                if (in_en != soft_en_reg) begin
                                    for (int i = 0; i < NUM_CHANNELS; i++) begin
                                        if (in_en) begin
                                            des_reg[i] <= save_reg[i];
                                        end else begin
                                            save_reg[i] <= des_reg[i];
                                            des_reg[i]  <= '0;
                                        end
                                    end
                                    fade_reg    <= 1'b1;
                                    soft_en_reg <= in_en;
                                end
                            end
                            ledfad_pkg::REQ_FAULT: begin
                                scale_reg     <= ledfad_pkg::SCALE_ONE;
                                sensor_ok_reg <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LUX_CLAMP: begin
                    if (lux_reg > max_reg) begin
                        lux_reg <= max_reg;
                    end
                    state_reg <= S_LUX_HYST;
                end
                S_LUX_HYST: begin
                    if (lux_skip) begin
                        state_reg <= S_IDLE;
                    end else if (max_reg == '0) begin
                        scale_reg    <= ledfad_pkg::SCALE_ONE;
                        last_lux_reg <= lux_reg;
                        have_lux_reg <= 1'b1;
                        fade_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end else begin
                        state_reg <= S_LUX_DIV;
                    end
                end
                S_LUX_DIV: begin
                    if (div_st.done) begin
                        scale_reg    <= ledfad_pkg::SCALE_ONE - div_q;
                        last_lux_reg <= lux_reg;
                        have_lux_reg <= 1'b1;
                        fade_reg     <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_TGT: begin
                    tgt_reg   <= tgt_prod[23:16];
                    state_reg <= S_STEP;
                end
                S_STEP: begin
                    cur_reg[ch_reg] <= nxt;
                    lvl_reg   <= nxt;
                    moved_reg <= moved;
                    any_reg   <= any_reg | moved;
                    state_reg <= S_PWM;
                end
                S_PWM: begin
                    if (pwm_done) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {1'b0, moved_reg, (lvl_reg != '0), pwm_pw,
                                         lvl_reg, 3'(ch_reg)};
                        m_tlast_reg  <= last_ch;
                        if (last_ch) begin
                            if (!any_reg) begin
                                fade_reg <= 1'b0;
                            end
                            state_reg <= S_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + 1'b1;
                            state_reg <= S_TGT;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_div_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> state_reg == S_LUX_DIV)
        else $error("divider finished outside the lux wait");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_st.busy)
        else $error("divider started while still busy");

    a_last_is_top_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tdata[2:0] == 3'(NUM_CHANNELS - 1))
        else $error("tick end flagged on the wrong channel");

    a_on_matches_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[21] == (m_tdata[10:3] != '0)))
        else $error("output enable disagrees with level");

    a_pulse_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[20:11] <= 10'd650)
        else $error("pulse width beyond curve maximum");
endmodule
`default_nettype wire
